// ===== src/rgb_pixel_color_converter_core_defines.svh =====
// assertion macros used by the pixel converter core
`ifndef RGB_PIXEL_COLOR_CONVERTER_CORE_DEFINES_SVH
`define RGB_PIXEL_COLOR_CONVERTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RPCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rpcc assertion failed");
`define RPCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpcc assertion failed");
`else
`define RPCC_ASSERT(lbl, prop)
`define RPCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/rpcc_pkg.sv =====
// shared constants and types of the pixel color converter
package rpcc_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned IN_MAX_W        = 16;
  localparam int unsigned PADDR_W         = 4;
  localparam int unsigned PDATA_W         = 32;

  // conversion modes
  localparam logic [2:0] MODE_BITMAP  = 3'd0;
  localparam logic [2:0] MODE_GRAY    = 3'd1;
  localparam logic [2:0] MODE_ISOLATE = 3'd2;
  localparam logic [2:0] MODE_REMOVE  = 3'd3;
  localparam logic [2:0] MODE_SEPIA   = 3'd4;

  // channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_CHANNEL  = 2'd1;
  localparam logic [1:0] REG_IN_MAX   = 2'd2;
  localparam logic [1:0] REG_GRAY_MAX = 2'd3;

  // reset values
  localparam logic [2:0]          MODE_RST     = MODE_BITMAP;
  localparam logic [1:0]          CHANNEL_RST  = CH_RED;
  localparam logic [IN_MAX_W-1:0] IN_MAX_RST   = 16'd255;
  localparam logic [IN_MAX_W-1:0] GRAY_MAX_RST = 16'd255;

  // sepia matrix in thousandths, row per output channel
  localparam int unsigned SEPIA_DEN = 1000;
  localparam logic [9:0] SEPIA_WT [3][3] = '{
    '{10'd393, 10'd769, 10'd189},
    '{10'd349, 10'd686, 10'd168},
    '{10'd272, 10'd534, 10'd131}
  };

  // how the mono field is formed at the output
  typedef struct packed {
    logic gray_en;   // mono comes from the divider
    logic gray_zero; // zero input maximum
    logic gray_sat;  // quotient above the field maximum
    logic bit_val;   // bitmap bit, zero outside bitmap mode
  } mono_ctl_t;

endpackage

// ===== src/rpcc_pix_if.sv =====
// input pixel channel
interface rpcc_pix_if #(
  parameter int unsigned SAMPLE_BITS = rpcc_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] red;
  logic [SAMPLE_BITS-1:0] green;
  logic [SAMPLE_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== src/rpcc_res_if.sv =====
// converted pixel channel
interface rpcc_res_if #(
  parameter int unsigned SAMPLE_BITS = rpcc_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] out_red;
  logic [SAMPLE_BITS-1:0] out_green;
  logic [SAMPLE_BITS-1:0] out_blue;
  logic [SAMPLE_BITS-1:0] mono_value;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output mono_value, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input mono_value, output ready);
endinterface

// ===== src/rgb_pixel_color_converter_core.sv =====
// pixel color converter top level: config registers, front pipeline, divider, output register
//
//  channel   dir   handshake            payload
//  pixel     in    valid / ready        red, green, blue
//  result    out   valid / ready        out_red, out_green, out_blue, mono_value
//  apb       in    psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// one item per clock sustained while the result side is ready; the depth is set by the
// grayscale divider, which resolves one quotient bit per stage
// three front stages: sums and sepia products, reciprocal multiply, mode select
// every stage has its own valid bit and loads when it is empty or its successor
// moves, so a stall on the result side fills bubbles and drops nothing
// rst is synchronous and clears valid bits and config registers only
module rgb_pixel_color_converter_core #(
  parameter int unsigned SAMPLE_BITS = rpcc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  rpcc_pix_if.sink                      pixel,
  rpcc_res_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpcc_pkg::PADDR_W-1:0]  paddr,
  input  logic [rpcc_pkg::PDATA_W-1:0]  pwdata,
  output logic [rpcc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned SB       = SAMPLE_BITS;
  localparam int unsigned IMW      = rpcc_pkg::IN_MAX_W;
  localparam int unsigned SUM_W    = SB + 2;
  // largest sepia row sum is 1351, below 2^11
  localparam int unsigned ACC_W    = SB + 11;
  localparam int unsigned SEP_K    = ACC_W + 10;
  localparam longint unsigned SEP_M =
    ((64'd1 << SEP_K) + 64'(rpcc_pkg::SEPIA_DEN) - 64'd1) / 64'(rpcc_pkg::SEPIA_DEN);
  localparam int unsigned SEP_M_W  = ACC_W + 1;
  localparam logic [SEP_M_W-1:0] SEP_M_V = SEP_M[SEP_M_W-1:0];
  localparam int unsigned PROD_W   = ACC_W + SEP_M_W;
  localparam int unsigned SQ_W     = SB + 1;
  localparam int unsigned MX_W     = (SQ_W > IMW) ? SQ_W : IMW;
  localparam int unsigned DSR_W    = IMW + 2;
  localparam int unsigned DVD_W    = SUM_W + IMW;
  localparam int unsigned CMP_W    = (SUM_W + 1 > DSR_W) ? SUM_W + 1 : DSR_W;
  localparam int unsigned CTL_W    = $bits(rpcc_pkg::mono_ctl_t);
  localparam int unsigned SIDE_W   = 3 * SB + CTL_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0]     mode;
  logic [1:0]     channel_select;
  logic [IMW-1:0] in_max;
  logic [IMW-1:0] gray_max;
  logic [1:0]     reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= rpcc_pkg::MODE_RST;
      channel_select <= rpcc_pkg::CHANNEL_RST;
      in_max         <= rpcc_pkg::IN_MAX_RST;
      gray_max       <= rpcc_pkg::GRAY_MAX_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        rpcc_pkg::REG_MODE:     mode           <= pwdata[2:0];
        rpcc_pkg::REG_CHANNEL:  channel_select <= pwdata[1:0];
        rpcc_pkg::REG_IN_MAX:   in_max         <= pwdata[IMW-1:0];
        rpcc_pkg::REG_GRAY_MAX: gray_max       <= pwdata[IMW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rpcc_pkg::REG_MODE:     prdata = rpcc_pkg::PDATA_W'(mode);
      rpcc_pkg::REG_CHANNEL:  prdata = rpcc_pkg::PDATA_W'(channel_select);
      rpcc_pkg::REG_IN_MAX:   prdata = rpcc_pkg::PDATA_W'(in_max);
      rpcc_pkg::REG_GRAY_MAX: prdata = rpcc_pkg::PDATA_W'(gray_max);
      default:                prdata = '0;
    endcase
  end

  // divisor for grayscale, 3 * in_max
  logic [DSR_W-1:0] divisor;
  assign divisor = DSR_W'(in_max) + DSR_W'({in_max, 1'b0});

  // channel select value 3 aliases blue
  logic [1:0] sel;
  assign sel = (channel_select >= rpcc_pkg::CH_BLUE) ? rpcc_pkg::CH_BLUE : channel_select;

  // ---------------------------------------------------------------------------
  // stage 1: samples, channel sum, sepia weighted sums
  // ---------------------------------------------------------------------------
  logic             v1, rdy1;
  logic [SB-1:0]    px1  [3];
  logic [SUM_W-1:0] sum1;
  logic [ACC_W-1:0] acc1 [3];

  logic             v2, rdy2;
  logic [SB-1:0]    px2  [3];
  logic [DVD_W-1:0] dvd2;
  logic [SQ_W-1:0]  sq2  [3];
  logic             bm2;

  logic             v3, rdy3;
  logic [SB-1:0]    col3 [3];
  logic [DVD_W-1:0] dvd3;
  rpcc_pkg::mono_ctl_t ctl3;

  logic              div_in_ready;
  logic              div_out_valid;
  logic              div_out_ready;
  logic [SB-1:0]     div_quot;
  logic [SIDE_W-1:0] div_side;
  logic [SIDE_W-1:0] side3;

  logic              vo;

  assign rdy1        = !v1 || rdy2;
  assign rdy2        = !v2 || rdy3;
  assign rdy3        = !v3 || div_in_ready;
  assign pixel.ready = rdy1;

  logic [SB-1:0] px_in [3];
  assign px_in[0] = pixel.red;
  assign px_in[1] = pixel.green;
  assign px_in[2] = pixel.blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= pixel.valid;
    end
    if (rdy1 && pixel.valid) begin
      for (int k = 0; k < 3; k++) begin
        px1[k]  <= px_in[k];
        acc1[k] <= ACC_W'(rpcc_pkg::SEPIA_WT[k][0]) * ACC_W'(px_in[0])
                 + ACC_W'(rpcc_pkg::SEPIA_WT[k][1]) * ACC_W'(px_in[1])
                 + ACC_W'(rpcc_pkg::SEPIA_WT[k][2]) * ACC_W'(px_in[2]);
      end
      sum1 <= SUM_W'(px_in[0]) + SUM_W'(px_in[1]) + SUM_W'(px_in[2]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: grayscale dividend, sepia divide by 1000 via reciprocal, bitmap test
  // ---------------------------------------------------------------------------
  // ceiling reciprocal with shift SEP_K is exact for every sum below 2^ACC_W
  logic [PROD_W-1:0] sep_prod [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sep_prod[k] = PROD_W'(acc1[k]) * PROD_W'(SEP_M_V);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      for (int k = 0; k < 3; k++) begin
        px2[k] <= px1[k];
        sq2[k] <= sep_prod[k][SEP_K +: SQ_W];
      end
      dvd2 <= DVD_W'(sum1) * DVD_W'(gray_max);
      // dark when 2*sum < 3*in_max
      bm2  <= CMP_W'({sum1, 1'b0}) < CMP_W'(divisor);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: per-mode color result and mono control
  // ---------------------------------------------------------------------------
  logic [SB-1:0]       col_next [3];
  rpcc_pkg::mono_ctl_t ctl_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (mode)
        rpcc_pkg::MODE_ISOLATE: col_next[k] = (2'(k) == sel) ? px2[k] : '0;
        rpcc_pkg::MODE_REMOVE:  col_next[k] = (2'(k) == sel) ? '0 : px2[k];
        rpcc_pkg::MODE_SEPIA: begin
          // saturate at in_max, then keep the field width
          if (MX_W'(sq2[k]) > MX_W'(in_max)) begin
            col_next[k] = SB'(in_max);
          end else begin
            col_next[k] = SB'(sq2[k]);
          end
        end
        default:                col_next[k] = '0;
      endcase
    end
    ctl_next.gray_en   = (mode == rpcc_pkg::MODE_GRAY);
    ctl_next.gray_zero = (in_max == '0);
    // quotient reaches 2^SB when the dividend is at least divisor << SB
    ctl_next.gray_sat  = dvd2 >= {divisor, SB'(0)};
    ctl_next.bit_val   = (mode == rpcc_pkg::MODE_BITMAP) && bm2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      for (int k = 0; k < 3; k++) begin
        col3[k] <= col_next[k];
      end
      dvd3 <= dvd2;
      ctl3 <= ctl_next;
    end
  end

  assign side3 = {col3[2], col3[1], col3[0], ctl3};

  // ---------------------------------------------------------------------------
  // grayscale divider, colors and mono control ride along as sideband
  // ---------------------------------------------------------------------------
  rpcc_divider #(
    .SAMPLE_BITS (SB),
    .DVD_W       (DVD_W),
    .DSR_W       (DSR_W),
    .SIDE_W      (SIDE_W)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v3),
    .in_ready    (div_in_ready),
    .in_dividend (dvd3),
    .in_side     (side3),
    .divisor     (divisor),
    .out_valid   (div_out_valid),
    .out_ready   (div_out_ready),
    .out_quot    (div_quot),
    .out_side    (div_side)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  rpcc_pkg::mono_ctl_t ctl_out;
  logic [SB-1:0]       mono_next;
  logic [SB-1:0]       out_col [3];

  assign ctl_out       = rpcc_pkg::mono_ctl_t'(div_side[CTL_W-1:0]);
  assign div_out_ready = !vo || result.ready;

  always_comb begin
    if (ctl_out.gray_en) begin
      if (ctl_out.gray_zero) begin
        mono_next = '0;
      end else if (ctl_out.gray_sat) begin
        mono_next = '1;
      end else begin
        mono_next = div_quot;
      end
    end else begin
      mono_next = SB'(ctl_out.bit_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (div_out_ready) begin
      vo <= div_out_valid;
    end
    if (div_out_ready && div_out_valid) begin
      out_col[0] <= div_side[CTL_W +: SB];
      out_col[1] <= div_side[CTL_W + SB +: SB];
      out_col[2] <= div_side[CTL_W + 2 * SB +: SB];
      result.mono_value <= mono_next;
    end
  end

  assign result.valid     = vo;
  assign result.out_red   = out_col[0];
  assign result.out_green = out_col[1];
  assign result.out_blue  = out_col[2];

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "rgb_pixel_color_converter_core_defines.svh"

  // an empty first stage always takes an item
  `RPCC_ASSERT(a_empty_takes, !v1 |-> pixel.ready)
  // an accepted pixel occupies stage 1 next cycle
  `RPCC_ASSERT_NEXT(a_accept_fills, pixel.valid && pixel.ready, v1)
  // a stage 3 item blocked by the divider keeps its dividend
  `RPCC_ASSERT_NEXT(a_s3_holds, v3 && !div_in_ready, v3 && $stable(dvd3))
  // an item leaving the divider lands in the output register
  `RPCC_ASSERT_NEXT(a_out_loads, div_out_valid && div_out_ready, result.valid)

endmodule

// ===== src/rpcc_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
module rpcc_divider #(
  parameter int unsigned SAMPLE_BITS = rpcc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DVD_W       = SAMPLE_BITS + 18,
  parameter int unsigned DSR_W       = 18,
  parameter int unsigned SIDE_W      = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [DVD_W-1:0]       in_dividend,
  input  logic [SIDE_W-1:0]      in_side,
  input  logic [DSR_W-1:0]       divisor,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_quot,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int unsigned SB = SAMPLE_BITS;

  logic                   v    [SB];
  logic                   rdy  [SB];
  logic [DVD_W-1:0]       rem  [SB];
  logic [SB-1:0]          quot [SB];
  logic [SIDE_W-1:0]      side [SB];

  for (genvar j = 0; j < SB; j++) begin : g_stage
    localparam int unsigned BIT = SB - 1 - j;

    logic              p_valid;
    logic [DVD_W-1:0]  p_rem;
    logic [SB-1:0]     p_quot;
    logic [SIDE_W-1:0] p_side;
    logic              down_rdy;
    logic [DVD_W-1:0]  shifted;
    logic              ge;

    if (j == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_rem   = in_dividend;
      assign p_quot  = '0;
      assign p_side  = in_side;
    end else begin : g_next
      assign p_valid = v[j-1];
      assign p_rem   = rem[j-1];
      assign p_quot  = quot[j-1];
      assign p_side  = side[j-1];
    end

    if (j == SB - 1) begin : g_last
      assign down_rdy = out_ready;
    end else begin : g_mid
      assign down_rdy = rdy[j+1];
    end

    assign rdy[j]  = !v[j] || down_rdy;
    assign shifted = DVD_W'(divisor) << BIT;
    assign ge      = p_rem >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= p_valid;
      end
      if (rdy[j] && p_valid) begin
        rem[j]  <= ge ? (p_rem - shifted) : p_rem;
        quot[j] <= p_quot | (SB'(ge) << BIT);
        side[j] <= p_side;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[SB-1];
  assign out_quot  = quot[SB-1];
  assign out_side  = side[SB-1];

endmodule
